// ----- rtl/pee_pkg.sv -----
// package for the postfix expression evaluator
// holds stack sizing, character codes, error codes and the sequencer state type
// no dependencies
package pee_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int SYMBOL_W    = 8;
   localparam int ERROR_W     = 3;
   localparam int STEP_W      = $clog2(DATA_W);

   localparam logic [SYMBOL_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [SYMBOL_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [SYMBOL_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [SYMBOL_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [SYMBOL_W-1:0] CHAR_STAR  = 8'h2A;
   localparam logic [SYMBOL_W-1:0] CHAR_SLASH = 8'h2F;

   typedef enum logic [ERROR_W-1:0] {
      ERR_OK        = 3'd0,
      ERR_UNDERFLOW = 3'd1,
      ERR_OVERFLOW  = 3'd2,
      ERR_DIVZERO   = 3'd3,
      ERR_EMPTY     = 3'd4
   } err_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_FETCH,
      S_DIVIDE,
      S_WRITE,
      S_DONE
   } state_type;

endpackage

// ----- rtl/pee_if.sv -----
// valid/ready channel interfaces for the postfix expression evaluator
// request carries one character, response carries the value and error code
// depends on pee_pkg
interface pee_req_if;
   logic                         valid;
   logic                         ready;
   logic [pee_pkg::SYMBOL_W-1:0] symbol;
   logic                         last;

   modport source (output valid, output symbol, output last, input ready);
   modport sink (input valid, input symbol, input last, output ready);
   modport monitor (input valid, input symbol, input last, input ready);
endinterface

interface pee_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [pee_pkg::DATA_W-1:0] value;
   logic [pee_pkg::ERROR_W-1:0]       error;

   modport source (output valid, output value, output error, input ready);
   modport sink (input valid, input value, input error, output ready);
   modport monitor (input valid, input value, input error, input ready);
endinterface

// ----- rtl/pee_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module pee_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/postfix_expression_evaluator_unit.sv -----
// postfix expression evaluator: operand stack in ram, sequencer, iterative divider
// transactions in on req_ch (one character each), out on rsp_ch
// depends on pee_pkg, pee_if, pee_ram
//
// usage
//   req_ch carries one ascii character and a last flag per transaction; digits
//   push, + - * / pop two operands and push the result, anything else is skipped
//   rsp_ch carries one transaction per expression: top of stack and the first
//   error (underflow, overflow, divide by zero, empty at end)
//   req_ch.ready is high only while the sequencer is idle
//   a digit or ignored character passes through decode and done; + - *
//   pass through decode, fetch, write and done; / also runs the radix-2
//   restoring divider, one quotient bit per cycle; divide by zero skips it
//   the stack ram has one write and one registered read port; the top of
//   stack is held in a register so an operator needs only one ram read
//   the response sits in an output register; the next expression proceeds
//   while it waits, and only the final character of that next expression
//   waits for the register to drain when rsp_ch.ready stays low
//   reset is synchronous: it clears the stack count, the sticky error and
//   rsp_ch.valid; ram contents are left as they are
module postfix_expression_evaluator_unit (
   input  logic              clock,
   input  logic              reset,
   pee_req_if.sink           req_ch,
   pee_rsp_if.source         rsp_ch
);

   pee_pkg::state_type state_ff, state_in;

   logic [pee_pkg::SYMBOL_W-1:0] symbol_ff, symbol_in;
   logic                         last_ff, last_in;
   logic [pee_pkg::COUNT_W-1:0]  count_ff, count_in;
   pee_pkg::err_type             err_ff, err_in;
   logic [pee_pkg::DATA_W-1:0]   tos_ff, tos_in;
   logic [pee_pkg::DATA_W-1:0]   result_ff, result_in;
   logic [pee_pkg::DATA_W-1:0]   rem_ff, rem_in;
   logic [pee_pkg::DATA_W-1:0]   quot_ff, quot_in;
   logic [pee_pkg::DATA_W-1:0]   divisor_ff, divisor_in;
   logic                         neg_ff, neg_in;
   logic [pee_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [pee_pkg::DATA_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [pee_pkg::ERROR_W-1:0]  rsp_error_ff, rsp_error_in;

   logic                         ram_wr_en;
   logic [pee_pkg::ADDR_W-1:0]   ram_wr_addr;
   logic [pee_pkg::DATA_W-1:0]   ram_wr_data;
   logic [pee_pkg::ADDR_W-1:0]   ram_rd_addr;
   logic [pee_pkg::DATA_W-1:0]   ram_rd_data;

   logic                         accept;
   logic                         is_digit;
   logic                         is_oper;
   logic                         out_free;
   logic [pee_pkg::COUNT_W-1:0]  count_m1;
   logic [pee_pkg::COUNT_W-1:0]  count_m2;
   logic [pee_pkg::DATA_W:0]     div_shift;
   logic [pee_pkg::DATA_W:0]     div_trial;
   logic [pee_pkg::DATA_W-1:0]   left_mag;
   logic [pee_pkg::DATA_W-1:0]   right_mag;
   logic [pee_pkg::DATA_W-1:0]   push_value;

   pee_ram #(
      .WIDTH (pee_pkg::DATA_W),
      .DEPTH (pee_pkg::STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ch.ready = (state_ff == pee_pkg::S_IDLE) && !reset;
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.value = $signed(rsp_value_ff);
   assign rsp_ch.error = rsp_error_ff;

   assign is_digit = (symbol_ff >= pee_pkg::CHAR_ZERO) && (symbol_ff <= pee_pkg::CHAR_NINE);
   assign is_oper  = (symbol_ff == pee_pkg::CHAR_PLUS) || (symbol_ff == pee_pkg::CHAR_MINUS) ||
                     (symbol_ff == pee_pkg::CHAR_STAR) || (symbol_ff == pee_pkg::CHAR_SLASH);

   assign count_m1 = count_ff - pee_pkg::COUNT_W'(1);
   assign count_m2 = count_ff - pee_pkg::COUNT_W'(2);

   // restoring divider step
   assign div_shift = {rem_ff, quot_ff[pee_pkg::DATA_W-1]};
   assign div_trial = div_shift - {1'b0, divisor_ff};

   assign left_mag  = ram_rd_data[pee_pkg::DATA_W-1] ? (~ram_rd_data + 1'b1) : ram_rd_data;
   assign right_mag = tos_ff[pee_pkg::DATA_W-1] ? (~tos_ff + 1'b1) : tos_ff;

   // result of the operator: quotient with sign, or the registered alu result
   assign push_value = (symbol_ff != pee_pkg::CHAR_SLASH) ? result_ff :
                       (neg_ff ? (~quot_ff + 1'b1) : quot_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pee_pkg::S_IDLE: begin
            if (accept) begin
               state_in = pee_pkg::S_DECODE;
            end
         end
         pee_pkg::S_DECODE: begin
            if (is_oper && (count_ff >= pee_pkg::COUNT_W'(2))) begin
               state_in = pee_pkg::S_FETCH;
            end else begin
               state_in = pee_pkg::S_DONE;
            end
         end
         pee_pkg::S_FETCH: begin
            if ((symbol_ff == pee_pkg::CHAR_SLASH) && (tos_ff != '0)) begin
               state_in = pee_pkg::S_DIVIDE;
            end else begin
               state_in = pee_pkg::S_WRITE;
            end
         end
         pee_pkg::S_DIVIDE: begin
            if (step_ff == pee_pkg::STEP_W'(pee_pkg::DATA_W - 1)) begin
               state_in = pee_pkg::S_WRITE;
            end
         end
         pee_pkg::S_WRITE: begin
            state_in = pee_pkg::S_DONE;
         end
         pee_pkg::S_DONE: begin
            if (!last_ff || out_free) begin
               state_in = pee_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pee_pkg::S_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      symbol_in    = symbol_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      tos_in       = tos_ff;
      result_in    = result_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      divisor_in   = divisor_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      rsp_value_in = rsp_value_ff;
      rsp_error_in = rsp_error_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = count_ff[pee_pkg::ADDR_W-1:0];
      ram_wr_data  = push_value;
      ram_rd_addr  = count_m2[pee_pkg::ADDR_W-1:0];

      unique case (state_ff)
         pee_pkg::S_IDLE: begin
            if (accept) begin
               symbol_in = req_ch.symbol;
               last_in   = req_ch.last;
            end
         end
         pee_pkg::S_DECODE: begin
            if (is_digit) begin
               if (count_ff >= pee_pkg::COUNT_W'(pee_pkg::STACK_DEPTH)) begin
                  if (err_ff == pee_pkg::ERR_OK) begin
                     err_in = pee_pkg::ERR_OVERFLOW;
                  end
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = count_ff[pee_pkg::ADDR_W-1:0];
                  ram_wr_data = {{(pee_pkg::DATA_W - pee_pkg::SYMBOL_W){1'b0}},
                                 symbol_ff - pee_pkg::CHAR_ZERO};
                  tos_in      = ram_wr_data;
                  count_in    = count_ff + pee_pkg::COUNT_W'(1);
               end
            end else if (is_oper && (count_ff < pee_pkg::COUNT_W'(2))) begin
               if (err_ff == pee_pkg::ERR_OK) begin
                  err_in = pee_pkg::ERR_UNDERFLOW;
               end
            end
         end
         pee_pkg::S_FETCH: begin
            priority if (symbol_ff == pee_pkg::CHAR_PLUS) begin
               result_in = ram_rd_data + tos_ff;
            end else if (symbol_ff == pee_pkg::CHAR_MINUS) begin
               result_in = ram_rd_data - tos_ff;
            end else if (symbol_ff == pee_pkg::CHAR_STAR) begin
               result_in = pee_pkg::DATA_W'(ram_rd_data * tos_ff);
            end else if (tos_ff == '0) begin
               quot_in = '0;
               neg_in  = 1'b0;
               if (err_ff == pee_pkg::ERR_OK) begin
                  err_in = pee_pkg::ERR_DIVZERO;
               end
            end else begin
               rem_in     = '0;
               quot_in    = left_mag;
               divisor_in = right_mag;
               neg_in     = ram_rd_data[pee_pkg::DATA_W-1] ^ tos_ff[pee_pkg::DATA_W-1];
               step_in    = '0;
            end
         end
         pee_pkg::S_DIVIDE: begin
            if (!div_trial[pee_pkg::DATA_W]) begin
               rem_in  = div_trial[pee_pkg::DATA_W-1:0];
               quot_in = {quot_ff[pee_pkg::DATA_W-2:0], 1'b1};
            end else begin
               rem_in  = div_shift[pee_pkg::DATA_W-1:0];
               quot_in = {quot_ff[pee_pkg::DATA_W-2:0], 1'b0};
            end
            step_in = step_ff + pee_pkg::STEP_W'(1);
         end
         pee_pkg::S_WRITE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = count_m2[pee_pkg::ADDR_W-1:0];
            ram_wr_data = push_value;
            tos_in      = push_value;
            count_in    = count_m1;
         end
         pee_pkg::S_DONE: begin
            if (last_ff && out_free) begin
               rsp_valid_in = 1'b1;
               if (count_ff != '0) begin
                  rsp_value_in = tos_ff;
                  rsp_error_in = err_ff;
               end else begin
                  rsp_value_in = '0;
                  rsp_error_in = (err_ff == pee_pkg::ERR_OK) ? pee_pkg::ERR_EMPTY : err_ff;
               end
               count_in = '0;
               err_in   = pee_pkg::ERR_OK;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pee_pkg::S_IDLE;
         count_ff     <= '0;
         err_ff       <= pee_pkg::ERR_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      symbol_ff    <= symbol_in;
      last_ff      <= last_in;
      tos_ff       <= tos_in;
      result_ff    <= result_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      divisor_ff   <= divisor_in;
      neg_ff       <= neg_in;
      step_ff      <= step_in;
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
   end

endmodule

// ----- rtl/pee_checker.sv -----
// port-level checks for the postfix expression evaluator, bound to the top level
// depends on pee_pkg, pee_if, postfix_expression_evaluator_unit
module pee_checker (
   input logic       clock,
   input logic       reset,
   pee_req_if.sink   req_ch,
   pee_rsp_if.source rsp_ch
);

   // held response keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=>
         rsp_ch.valid && $stable(rsp_ch.value) && $stable(rsp_ch.error))
      else $error("response changed while stalled");

   // block is busy in the cycle after it takes a transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("ready high right after a transaction");

   // error codes stay within the defined set
   a_error_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.error <= pee_pkg::ERROR_W'(pee_pkg::ERR_EMPTY)))
      else $error("undefined error code");

   // empty stack at end reports zero
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.error == pee_pkg::ERROR_W'(pee_pkg::ERR_EMPTY)) |->
         (rsp_ch.value == '0))
      else $error("nonzero value with empty stack");

   // no response right out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid after reset");

endmodule

bind postfix_expression_evaluator_unit pee_checker u_pee_checker (
   .clock  (clock),
   .reset  (reset),
   .req_ch (req_ch),
   .rsp_ch (rsp_ch)
);

// ----- tb/postfix_expression_evaluator_unit_test.sv -----
// testbench for postfix_expression_evaluator_unit: directed and random expressions,
// self-checking against an in-bench stack evaluator, random stalls on both channels
// depends on pee_pkg, pee_if and the rtl of the evaluator
module postfix_expression_evaluator_unit_test;

   localparam int PERIOD       = 10;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 350;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AFTER   = 10;
   localparam int DRAIN_CYCLES = 64;
   localparam int QUIET_LIMIT  = 3000;

   typedef struct packed {
      logic [pee_pkg::SYMBOL_W-1:0] symbol;
      logic                         last;
   } char_item_type;

   typedef struct {
      logic signed [pee_pkg::DATA_W-1:0] value;
      pee_pkg::err_type                  error;
   } expr_result_type;

   logic clock = 1'b0;
   logic reset;

   pee_req_if req_ch ();
   pee_rsp_if rsp_ch ();

   postfix_expression_evaluator_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #(PERIOD / 2) clock = ~clock;

   char_item_type   char_stream[$];
   expr_result_type expression_results[$];

   logic [pee_pkg::DATA_W-1:0] model_stack [pee_pkg::STACK_DEPTH];
   int                         model_count;
   pee_pkg::err_type           model_error;

   char_item_type next_char;
   int            send_left;
   int            take_left;
   int            hold_left;
   bit            hold_done;
   bit            send_calm      = 1'b0;
   bit            take_calm      = 1'b0;
   int            results_seen   = 0;
   int            sent_count     = 0;
   int            mismatch_count = 0;
   int            quiet_cycles;

   function automatic bit is_digit(logic [pee_pkg::SYMBOL_W-1:0] c);
      return c >= pee_pkg::CHAR_ZERO && c <= pee_pkg::CHAR_NINE;
   endfunction

   function automatic bit is_operator(logic [pee_pkg::SYMBOL_W-1:0] c);
      return c == pee_pkg::CHAR_PLUS || c == pee_pkg::CHAR_MINUS ||
             c == pee_pkg::CHAR_STAR || c == pee_pkg::CHAR_SLASH;
   endfunction

   // stack evaluator

   task automatic record_error(pee_pkg::err_type code);
      if (model_error == pee_pkg::ERR_OK) model_error = code;
   endtask

   task automatic push_operand(logic [pee_pkg::DATA_W-1:0] v);
      if (model_count >= pee_pkg::STACK_DEPTH) begin
         record_error(pee_pkg::ERR_OVERFLOW);
      end else begin
         model_stack[model_count] = v;
         model_count++;
      end
   endtask

   function automatic logic [pee_pkg::DATA_W-1:0] divide_toward_zero(
         logic [pee_pkg::DATA_W-1:0] num, logic [pee_pkg::DATA_W-1:0] den);
      logic [pee_pkg::DATA_W-1:0] mag_n, mag_d, quo;
      mag_n = num[pee_pkg::DATA_W-1] ? -num : num;
      mag_d = den[pee_pkg::DATA_W-1] ? -den : den;
      quo = mag_n / mag_d;
      return (num[pee_pkg::DATA_W-1] != den[pee_pkg::DATA_W-1]) ? -quo : quo;
   endfunction

   task automatic apply_operator(logic [pee_pkg::SYMBOL_W-1:0] op);
      logic [pee_pkg::DATA_W-1:0] rhs, lhs, res;
      if (model_count < 2) begin
         record_error(pee_pkg::ERR_UNDERFLOW);
         return;
      end
      rhs = model_stack[model_count - 1];
      lhs = model_stack[model_count - 2];
      model_count -= 2;
      case (op)
         pee_pkg::CHAR_PLUS: res = lhs + rhs;
         pee_pkg::CHAR_MINUS: res = lhs - rhs;
         pee_pkg::CHAR_STAR: res = lhs * rhs;
         default: begin
            if (rhs == '0) begin
               record_error(pee_pkg::ERR_DIVZERO);
               res = '0;
            end else begin
               res = divide_toward_zero(lhs, rhs);
            end
         end
      endcase
      push_operand(res);
   endtask

   task automatic evaluate_symbol(logic [pee_pkg::SYMBOL_W-1:0] sym, logic last);
      expr_result_type r;
      if (is_digit(sym)) push_operand(pee_pkg::DATA_W'(sym - pee_pkg::CHAR_ZERO));
      else if (is_operator(sym)) apply_operator(sym);
      if (last) begin
         r.value = '0;
         r.error = model_error;
         if (model_count > 0) r.value = model_stack[model_count - 1];
         else if (model_error == pee_pkg::ERR_OK) r.error = pee_pkg::ERR_EMPTY;
         expression_results.push_back(r);
         model_count = 0;
         model_error = pee_pkg::ERR_OK;
      end
   endtask

   // checking

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_result(logic signed [pee_pkg::DATA_W-1:0] value,
                               logic [pee_pkg::ERROR_W-1:0] error);
      expr_result_type want;
      if (expression_results.size() == 0) begin
         report_mismatch($sformatf("unexpected transaction value %0d error %0d", value, error));
         return;
      end
      want = expression_results.pop_front();
      if (value !== want.value)
         report_mismatch($sformatf("value %0d, predicted %0d", value, want.value));
      if (error !== want.error)
         report_mismatch($sformatf("error %0d, predicted %0d", error, want.error));
   endtask

   // stimulus

   task automatic queue_expression(logic [pee_pkg::SYMBOL_W-1:0] chars[$]);
      char_item_type it;
      foreach (chars[i]) begin
         it.symbol = chars[i];
         it.last = (i == chars.size() - 1);
         char_stream.push_back(it);
      end
   endtask

   task automatic queue_text(string text);
      logic [pee_pkg::SYMBOL_W-1:0] chars[$];
      for (int i = 0; i < text.len(); i++) chars.push_back(text[i]);
      queue_expression(chars);
   endtask

   function automatic logic [pee_pkg::SYMBOL_W-1:0] random_digit();
      return pee_pkg::CHAR_ZERO + pee_pkg::SYMBOL_W'($urandom_range(0, 9));
   endfunction

   function automatic logic [pee_pkg::SYMBOL_W-1:0] random_operator();
      case ($urandom_range(0, 3))
         0: return pee_pkg::CHAR_PLUS;
         1: return pee_pkg::CHAR_MINUS;
         2: return pee_pkg::CHAR_STAR;
         default: return pee_pkg::CHAR_SLASH;
      endcase
   endfunction

   function automatic logic [pee_pkg::SYMBOL_W-1:0] ignored_char();
      logic [pee_pkg::SYMBOL_W-1:0] c;
      do c = pee_pkg::SYMBOL_W'($urandom_range(0, 255));
      while (is_digit(c) || is_operator(c));
      return c;
   endfunction

   task automatic add_wellformed_expression();
      logic [pee_pkg::SYMBOL_W-1:0] chars[$];
      int depth;
      depth = 0;
      repeat ($urandom_range(1, 12)) begin
         if ($urandom_range(0, 7) == 0) chars.push_back(ignored_char());
         if (depth >= 2 && $urandom_range(0, 2) != 0) begin
            chars.push_back(random_operator());
            depth--;
         end else begin
            chars.push_back(random_digit());
            depth++;
         end
      end
      while (depth > 1 && $urandom_range(0, 5) != 0) begin
         chars.push_back(random_operator());
         depth--;
      end
      queue_expression(chars);
   endtask

   // fills the stack to the brim or past it, then folds it back down
   task automatic add_stack_filler();
      logic [pee_pkg::SYMBOL_W-1:0] chars[$];
      repeat (pee_pkg::STACK_DEPTH + $urandom_range(0, 3)) chars.push_back(random_digit());
      repeat ($urandom_range(0, pee_pkg::STACK_DEPTH + 4)) chars.push_back(random_operator());
      queue_expression(chars);
   endtask

   task automatic add_noise();
      logic [pee_pkg::SYMBOL_W-1:0] chars[$];
      repeat ($urandom_range(1, 8)) chars.push_back(pee_pkg::SYMBOL_W'($urandom_range(0, 255)));
      queue_expression(chars);
   endtask

   task automatic add_broken_expression();
      logic [pee_pkg::SYMBOL_W-1:0] chars[$];
      repeat ($urandom_range(1, 8))
         chars.push_back($urandom_range(0, 1) ? random_digit() : random_operator());
      queue_expression(chars);
   endtask

   function automatic int draw_wait(bit calm);
      return calm ? 0 : $urandom_range(0, 14);
   endfunction

   // driver

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.symbol <= '0;
         req_ch.last <= 1'b0;
         send_left = 0;
         model_count = 0;
         model_error = pee_pkg::ERR_OK;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            evaluate_symbol(req_ch.symbol, req_ch.last);
            sent_count++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_left != 0) begin
               send_left--;
               req_ch.valid <= 1'b0;
            end else if (char_stream.size() != 0) begin
               next_char = char_stream.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.symbol <= next_char.symbol;
               req_ch.last <= next_char.last;
               if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
               send_left = draw_wait(send_calm);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         take_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_result(rsp_ch.value, rsp_ch.error);
            results_seen++;
            if ($urandom_range(0, 29) == 0) take_calm = !take_calm;
            take_left = draw_wait(take_calm);
         end else if (take_left != 0) begin
            take_left--;
         end
         rsp_ch.ready <= (take_left == 0) && (hold_left == 0);
      end
   end

   // one long hold-off on the response side so the evaluator backs up

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && (results_seen >= HOLD_AFTER)) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [pee_pkg::SYMBOL_W-1:0] bound_chars[$];
      int directed_count;
      int total_items;
      int pick;

      reset = 1'b1;

      queue_text("12+");
      queue_text("34*");
      queue_text("07-2/");
      queue_text("50/");
      queue_text("+");
      // underflow with one operand, then a divide by zero that must not replace it
      queue_text("5+0/");
      queue_text(" ");
      bound_chars.push_back(8'h00);
      bound_chars.push_back(pee_pkg::CHAR_NINE);
      bound_chars.push_back(8'hFF);
      queue_expression(bound_chars);
      add_stack_filler();
      // most negative value divided by minus one
      queue_text("88*8*8*8*8*8*8*8*8*2*01-/");
      directed_count = char_stream.size();

      while (char_stream.size() < directed_count + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) add_wellformed_expression();
         else if (pick < 74) add_stack_filler();
         else if (pick < 87) add_noise();
         else add_broken_expression();
      end
      total_items = char_stream.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (sent_count < total_items || expression_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
